// ===== rtl/snfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// snfcs_pkg: shared types and constants of the SPI NOR command sequencer
// Action codes, phases, opcodes, queue entry and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package snfcs_pkg;

  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_SHIFT = 16;
  localparam int PAGE_W       = $clog2(PAGE_BYTES);
  localparam int CHUNK_W      = PAGE_W + 1;

  typedef enum logic [2:0] {
    ACT_SEL    = 3'd0,
    ACT_DESEL  = 3'd1,
    ACT_SEND   = 3'd2,
    ACT_RECV   = 3'd3,
    ACT_WAIT   = 3'd4,
    ACT_HOST   = 3'd5,
    ACT_NEED   = 3'd6,
    ACT_DONE   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_WBYTE = 2'd1,
    KIND_RX    = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_READ    = 4'd0,
    OP_WRITE   = 4'd1,
    OP_ERASE4K = 4'd2,
    OP_ERASE64 = 4'd3,
    OP_BULK    = 4'd4,
    OP_ID      = 4'd5,
    OP_STAT1   = 4'd6,
    OP_STAT2   = 4'd7,
    OP_STAT3   = 4'd8,
    OP_WRSTAT  = 4'd9,
    OP_DOWN    = 4'd10,
    OP_UP      = 4'd11
  } op_t;

  // Phase register of the sequencer.
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_READ_RX  = 5'd1,
    PH_WRITE_TX = 5'd2,
    PH_POLL     = 5'd3,
    PH_ID_RX    = 5'd4,
    PH_STAT_RX  = 5'd5,
    PH_EMIT     = 5'd6
  } phase_t;

  // Command bytes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR1 = 8'h05;
  localparam logic [7:0] CMD_RDSR2 = 8'h35;
  localparam logic [7:0] CMD_RDSR3 = 8'h15;
  localparam logic [7:0] CMD_WRSR  = 8'h01;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_SE4K  = 8'h20;
  localparam logic [7:0] CMD_SE64  = 8'hD8;
  localparam logic [7:0] CMD_BULK  = 8'hC7;
  localparam logic [7:0] CMD_JEDEC = 8'h9F;
  localparam logic [7:0] CMD_DOWN  = 8'hB9;
  localparam logic [7:0] CMD_UP    = 8'hAB;

  localparam logic [13:0] WAIT_WREN   = 14'd2;
  localparam logic [13:0] WAIT_PROG   = 14'd2000;
  localparam logic [13:0] WAIT_ERASE  = 14'd10000;
  localparam logic [13:0] WAIT_EPOLL  = 14'd100;
  localparam logic [13:0] WAIT_UP     = 14'd30;
  localparam logic [15:0] SECT_RESET  = 16'd32;
  localparam logic [15:0] SECT_DEFAULT = 16'd16; // 1048576 >> 16

  // One front item as queued to the back end.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  byte_value;
    logic [13:0] wait_us;
    logic [15:0] sector_count;
    logic        id_valid;
    logic        last;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  function automatic result_t mk(input logic [2:0] act, input logic [7:0] b,
                                 input logic [13:0] w);
    result_t r;
    r = '0;
    r.action     = act;
    r.byte_value = b;
    r.wait_us    = w;
    return r;
  endfunction

  // Capacity is 2^e bytes; sectors are 2^(e-16), zero below one sector.
  function automatic logic [15:0] cap_to_sect(input logic [4:0] e);
    logic [15:0] s;
    s = '0;
    if (e >= 5'(SECTOR_SHIFT)) s = 16'(32'(1) << (e - 5'(SECTOR_SHIFT)));
    return s;
  endfunction

  // Sector count decode from the three JEDEC ID bytes.
  function automatic logic [15:0] id_sectors(input logic [7:0] b0,
                                             input logic [7:0] b1,
                                             input logic [7:0] b2);
    logic [4:0] e;
    logic [15:0] s;
    e = '0;
    s = SECT_DEFAULT;
    if (b2 >= 8'd16 && b2 <= 8'd31) begin
      e = b2[4:0];
      s = cap_to_sect(e);
    end else if (b2 >= 8'd32 && b2 <= 8'd37) begin
      e = 5'(b2 - 8'd6);
      s = cap_to_sect(e);
    end else if ((b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h00) ||
                 (b0 == 8'hFF && b1 == 8'hFF && b2 == 8'hFF)) begin
      s = '0;
    end
    return s;
  endfunction

  function automatic logic id_ok(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2);
    return (b0 == 8'hEF || b0 == 8'h20) && (b1 == 8'h20 || b1 == 8'h40) &&
           b2 >= 8'd16 && b2 <= 8'd37;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/snfcs_if.sv =====
// ----------------------------------------------------------------------------
// snfcs_in_if / snfcs_out_if: valid/ready channels of the sequencer
// Input items and result items with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none
interface snfcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  op;
  logic [23:0] address;
  logic [15:0] length;
  logic [7:0]  data_byte;
  modport source (output valid, kind, op, address, length, data_byte, input ready);
  modport sink   (input valid, kind, op, address, length, data_byte, output ready);
endinterface

interface snfcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  byte_value;
  logic [13:0] wait_us;
  logic [15:0] sector_count;
  logic        id_valid;
  logic        last;
  modport source (output valid, action, byte_value, wait_us, sector_count, id_valid,
                  last, input ready);
  modport sink   (input valid, action, byte_value, wait_us, sector_count, id_valid,
                  last, output ready);
endinterface
`default_nettype wire

// ===== rtl/snfcs_front.sv =====
// ----------------------------------------------------------------------------
// snfcs_front: input stage and item queue
// Registers incoming items, drops kind 3 early, and buffers them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module snfcs_front (
  input  wire logic             clk,
  input  wire logic             rst,
  snfcs_in_if.sink              in_ch,
  output snfcs_pkg::item_t      q_item,
  output logic                  q_valid,
  input  wire logic             q_pop
);
  import snfcs_pkg::*;

  item_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               push;
  logic               pop;
  item_t              in_item;

  assign in_ch.ready = (count != (QPTR_W+1)'(QDEPTH));
  // Kind 3 items never cause results; classify and drop them here.
  assign push = in_ch.valid && in_ch.ready && (in_ch.kind != KIND_NONE);
  assign pop  = q_pop && (count != '0);

  always_comb begin
    in_item.kind      = in_ch.kind;
    in_item.op        = in_ch.op;
    in_item.address   = in_ch.address;
    in_item.length    = in_ch.length;
    in_item.data_byte = in_ch.data_byte;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  assign q_item  = mem[rd_ptr];
  assign q_valid = (count != '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH)) else $error("queue overflow");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count slip");
  a_cnt_dn: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1) else $error("count slip");
endmodule
`default_nettype wire

// ===== rtl/snfcs_back.sv =====
// ----------------------------------------------------------------------------
// snfcs_back: command sequencer
// Takes a queued item, builds its result list, emits a result each ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module snfcs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire snfcs_pkg::item_t q_item,
  input  wire logic          q_valid,
  output logic               q_pop,
  snfcs_out_if.source        out_ch
);
  import snfcs_pkg::*;

  localparam int NRES = 16;
  localparam int RI_W = $clog2(NRES);

  phase_t             phase, phase_next;
  phase_t             rest, rest_next;        // phase after the list drains
  logic [3:0]         cur_op, cur_op_next;
  logic [23:0]        cursor, cursor_next;
  logic [15:0]        remain, remain_next;
  logic [CHUNK_W-1:0] chunk, chunk_next;
  logic [7:0]         idb0, idb0_next, idb1, idb1_next;
  logic [1:0]         idx, idx_next;
  logic [15:0]        sectors, sectors_next;

  result_t            list [NRES];
  result_t            list_next [NRES];
  logic [RI_W:0]      n_res, n_res_next;
  logic [RI_W:0]      pos;
  logic               load;
  logic               out_fire;

  // Plan variables
  result_t            buf_r [NRES];
  logic [RI_W-1:0]    n;
  phase_t             ph;
  logic [CHUNK_W-1:0] cn;
  logic [CHUNK_W-1:0] room;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign q_pop    = load;
  assign load     = (phase != PH_EMIT) && q_valid;

  // Emit stage
  assign out_ch.valid        = (phase == PH_EMIT);
  assign out_ch.action       = list[pos[RI_W-1:0]].action;
  assign out_ch.byte_value   = list[pos[RI_W-1:0]].byte_value;
  assign out_ch.wait_us      = list[pos[RI_W-1:0]].wait_us;
  assign out_ch.sector_count = list[pos[RI_W-1:0]].sector_count;
  assign out_ch.id_valid     = list[pos[RI_W-1:0]].id_valid;
  assign out_ch.last         = (pos + 1'b1 == n_res);

  always_comb begin
    buf_r        = '{default: '0};
    n            = '0;
    ph           = phase;
    cur_op_next  = cur_op;
    cursor_next  = cursor;
    remain_next  = remain;
    chunk_next   = chunk;
    idb0_next    = idb0;
    idb1_next    = idb1;
    idx_next     = idx;
    sectors_next = sectors;
    cn           = '0;
    room         = '0;

    if (load) begin
      case (q_item.kind)
        KIND_REQ: begin
          if (phase == PH_IDLE) begin
            cur_op_next = q_item.op;
            case (q_item.op)
              OP_READ, OP_WRITE: begin
                if (q_item.length == '0) begin
                  buf_r[n] = mk(ACT_DONE, 8'd0, '0); buf_r[n].sector_count = sectors;
                  n = n + 1'b1; ph = PH_IDLE;
                end else begin
                  cursor_next = q_item.address;
                  remain_next = q_item.length;
                end
              end
              OP_ERASE4K, OP_ERASE64, OP_BULK, OP_WRSTAT: begin
                buf_r[n] = mk(ACT_SEL, 8'd0, '0);       n = n + 1'b1;
                buf_r[n] = mk(ACT_SEND, CMD_WREN, '0);  n = n + 1'b1;
                buf_r[n] = mk(ACT_DESEL, 8'd0, '0);     n = n + 1'b1;
                buf_r[n] = mk(ACT_WAIT, 8'd0, WAIT_WREN); n = n + 1'b1;
                buf_r[n] = mk(ACT_SEL, 8'd0, '0);       n = n + 1'b1;
                if (q_item.op == OP_BULK) begin
                  buf_r[n] = mk(ACT_SEND, CMD_BULK, '0); n = n + 1'b1;
                  buf_r[n] = mk(ACT_DESEL, 8'd0, '0);    n = n + 1'b1;
                end else if (q_item.op == OP_WRSTAT) begin
                  buf_r[n] = mk(ACT_SEND, CMD_WRSR, '0); n = n + 1'b1;
                  buf_r[n] = mk(ACT_SEND, q_item.data_byte, '0); n = n + 1'b1;
                  buf_r[n] = mk(ACT_DESEL, 8'd0, '0);    n = n + 1'b1;
                  buf_r[n] = mk(ACT_WAIT, 8'd0, WAIT_WREN); n = n + 1'b1;
                end else begin
                  buf_r[n] = mk(ACT_SEND, (q_item.op == OP_ERASE4K) ? CMD_SE4K : CMD_SE64,
                                '0); n = n + 1'b1;
                  buf_r[n] = mk(ACT_SEND, q_item.address[23:16], '0); n = n + 1'b1;
                  buf_r[n] = mk(ACT_SEND, q_item.address[15:8], '0);  n = n + 1'b1;
                  buf_r[n] = mk(ACT_SEND, q_item.address[7:0], '0);   n = n + 1'b1;
                  buf_r[n] = mk(ACT_DESEL, 8'd0, '0);    n = n + 1'b1;
                  buf_r[n] = mk(ACT_WAIT, 8'd0, WAIT_ERASE); n = n + 1'b1;
                end
                buf_r[n] = mk(ACT_SEL, 8'd0, '0);       n = n + 1'b1;
                buf_r[n] = mk(ACT_SEND, CMD_RDSR1, '0); n = n + 1'b1;
                buf_r[n] = mk(ACT_RECV, 8'd0, '0);      n = n + 1'b1;
                ph = PH_POLL;
              end
              OP_ID: begin
                buf_r[n] = mk(ACT_SEL, 8'd0, '0);       n = n + 1'b1;
                buf_r[n] = mk(ACT_SEND, CMD_JEDEC, '0); n = n + 1'b1;
                buf_r[n] = mk(ACT_RECV, 8'd0, '0);      n = n + 1'b1;
                idx_next = '0; ph = PH_ID_RX;
              end
              OP_STAT1, OP_STAT2, OP_STAT3: begin
                buf_r[n] = mk(ACT_SEL, 8'd0, '0); n = n + 1'b1;
                buf_r[n] = mk(ACT_SEND, (q_item.op == OP_STAT1) ? CMD_RDSR1 :
                              (q_item.op == OP_STAT2) ? CMD_RDSR2 : CMD_RDSR3, '0);
                n = n + 1'b1;
                buf_r[n] = mk(ACT_RECV, 8'd0, '0); n = n + 1'b1;
                ph = PH_STAT_RX;
              end
              OP_DOWN, OP_UP: begin
                buf_r[n] = mk(ACT_SEL, 8'd0, '0); n = n + 1'b1;
                buf_r[n] = mk(ACT_SEND, (q_item.op == OP_DOWN) ? CMD_DOWN : CMD_UP, '0);
                n = n + 1'b1;
                buf_r[n] = mk(ACT_DESEL, 8'd0, '0); n = n + 1'b1;
                if (q_item.op == OP_UP) begin
                  buf_r[n] = mk(ACT_WAIT, 8'd0, WAIT_UP); n = n + 1'b1;
                end
                buf_r[n] = mk(ACT_DONE, 8'd0, '0); buf_r[n].sector_count = sectors;
                n = n + 1'b1; ph = PH_IDLE;
              end
              default: begin
                buf_r[n] = mk(ACT_DONE, 8'd0, '0); buf_r[n].sector_count = sectors;
                n = n + 1'b1; ph = PH_IDLE;
              end
            endcase
          end
        end
        KIND_WBYTE: begin
          if (phase == PH_WRITE_TX) begin
            buf_r[n] = mk(ACT_SEND, q_item.data_byte, '0); n = n + 1'b1;
            if (chunk != '0) chunk_next = chunk - 1'b1;
            if (chunk > CHUNK_W'(1)) begin
              buf_r[n] = mk(ACT_NEED, 8'd0, '0); n = n + 1'b1;
            end else begin
              buf_r[n] = mk(ACT_DESEL, 8'd0, '0);      n = n + 1'b1;
              buf_r[n] = mk(ACT_WAIT, 8'd0, WAIT_PROG); n = n + 1'b1;
              buf_r[n] = mk(ACT_SEL, 8'd0, '0);        n = n + 1'b1;
              buf_r[n] = mk(ACT_SEND, CMD_RDSR1, '0);  n = n + 1'b1;
              buf_r[n] = mk(ACT_RECV, 8'd0, '0);       n = n + 1'b1;
              ph = PH_POLL;
            end
          end
        end
        KIND_RX: begin
          case (phase)
            PH_READ_RX: begin
              buf_r[n] = mk(ACT_HOST, q_item.data_byte, '0); n = n + 1'b1;
              if (chunk != '0) chunk_next = chunk - 1'b1;
              if (chunk > CHUNK_W'(1)) begin
                buf_r[n] = mk(ACT_RECV, 8'd0, '0); n = n + 1'b1;
              end else begin
                buf_r[n] = mk(ACT_DESEL, 8'd0, '0);      n = n + 1'b1;
                buf_r[n] = mk(ACT_WAIT, 8'd0, WAIT_WREN); n = n + 1'b1;
                if (remain == '0) begin
                  buf_r[n] = mk(ACT_DONE, 8'd0, '0); buf_r[n].sector_count = sectors;
                  n = n + 1'b1; ph = PH_IDLE;
                end
              end
            end
            PH_POLL: begin
              buf_r[n] = mk(ACT_DESEL, 8'd0, '0); n = n + 1'b1;
              if (q_item.data_byte[0]) begin
                if (cur_op == OP_WRITE) begin
                  buf_r[n] = mk(ACT_WAIT, 8'd0, WAIT_PROG); n = n + 1'b1;
                end else if (cur_op == OP_ERASE4K || cur_op == OP_ERASE64) begin
                  buf_r[n] = mk(ACT_WAIT, 8'd0, WAIT_EPOLL); n = n + 1'b1;
                end
                buf_r[n] = mk(ACT_SEL, 8'd0, '0);       n = n + 1'b1;
                buf_r[n] = mk(ACT_SEND, CMD_RDSR1, '0); n = n + 1'b1;
                buf_r[n] = mk(ACT_RECV, 8'd0, '0);      n = n + 1'b1;
              end else if (!(cur_op == OP_WRITE && remain != '0)) begin
                buf_r[n] = mk(ACT_DONE, 8'd0, '0); buf_r[n].sector_count = sectors;
                n = n + 1'b1; ph = PH_IDLE;
              end
            end
            PH_ID_RX: begin
              if (idx == 2'd0) begin
                idb0_next = q_item.data_byte; idx_next = 2'd1;
                buf_r[n] = mk(ACT_RECV, 8'd0, '0); n = n + 1'b1;
              end else if (idx == 2'd1) begin
                idb1_next = q_item.data_byte; idx_next = 2'd2;
                buf_r[n] = mk(ACT_RECV, 8'd0, '0); n = n + 1'b1;
              end else begin
                idx_next = '0;
                sectors_next = id_sectors(idb0, idb1, q_item.data_byte);
                buf_r[n] = mk(ACT_DESEL, 8'd0, '0); n = n + 1'b1;
                buf_r[n] = mk(ACT_DONE, 8'd0, '0);
                buf_r[n].sector_count = sectors_next;
                buf_r[n].id_valid = id_ok(idb0, idb1, q_item.data_byte);
                n = n + 1'b1; ph = PH_IDLE;
              end
            end
            PH_STAT_RX: begin
              buf_r[n] = mk(ACT_DESEL, 8'd0, '0); n = n + 1'b1;
              buf_r[n] = mk(ACT_DONE, q_item.data_byte, '0);
              buf_r[n].sector_count = sectors;
              n = n + 1'b1; ph = PH_IDLE;
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      // Start of a chunk: new read/write, read chunk end, or write poll clear.
      if ((q_item.kind == KIND_REQ && phase == PH_IDLE &&
           (q_item.op == OP_READ || q_item.op == OP_WRITE) && q_item.length != '0) ||
          (q_item.kind == KIND_RX && phase == PH_READ_RX && chunk <= CHUNK_W'(1) &&
           remain != '0) ||
          (q_item.kind == KIND_RX && phase == PH_POLL && !q_item.data_byte[0] &&
           cur_op == OP_WRITE && remain != '0)) begin
        room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(cursor_next[PAGE_W-1:0]);
        cn   = ({1'b0, remain_next} < 17'(room)) ? CHUNK_W'(remain_next) : room;
        chunk_next  = cn;
        remain_next = remain_next - 16'(cn);
        if (cur_op_next == OP_WRITE) begin
          buf_r[n] = mk(ACT_SEL, 8'd0, '0);       n = n + 1'b1;
          buf_r[n] = mk(ACT_SEND, CMD_WREN, '0);  n = n + 1'b1;
          buf_r[n] = mk(ACT_DESEL, 8'd0, '0);     n = n + 1'b1;
          buf_r[n] = mk(ACT_WAIT, 8'd0, WAIT_WREN); n = n + 1'b1;
          buf_r[n] = mk(ACT_SEL, 8'd0, '0);       n = n + 1'b1;
          buf_r[n] = mk(ACT_SEND, CMD_PP, '0);    n = n + 1'b1;
        end else begin
          buf_r[n] = mk(ACT_SEL, 8'd0, '0);       n = n + 1'b1;
          buf_r[n] = mk(ACT_SEND, CMD_READ, '0);  n = n + 1'b1;
        end
        buf_r[n] = mk(ACT_SEND, cursor_next[23:16], '0); n = n + 1'b1;
        buf_r[n] = mk(ACT_SEND, cursor_next[15:8], '0);  n = n + 1'b1;
        buf_r[n] = mk(ACT_SEND, cursor_next[7:0], '0);   n = n + 1'b1;
        if (cur_op_next == OP_WRITE) begin
          buf_r[n] = mk(ACT_NEED, 8'd0, '0); n = n + 1'b1; ph = PH_WRITE_TX;
        end else begin
          buf_r[n] = mk(ACT_RECV, 8'd0, '0); n = n + 1'b1; ph = PH_READ_RX;
        end
        cursor_next = cursor_next + 24'(cn);
      end
    end
  end

  always_comb begin
    phase_next = phase;
    rest_next  = rest;
    n_res_next = n_res;
    list_next  = list;
    if (load) begin
      list_next  = buf_r;
      n_res_next = (RI_W+1)'(n);
      if (n != '0) begin
        phase_next = PH_EMIT;
        rest_next  = ph;
      end else begin
        phase_next = ph;
      end
    end else if (out_fire && out_ch.last) begin
      phase_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      rest    <= PH_IDLE;
      pos     <= '0;
      n_res   <= '0;
      cur_op  <= '0;
      cursor  <= '0;
      remain  <= '0;
      chunk   <= '0;
      idb0    <= '0;
      idb1    <= '0;
      idx     <= '0;
      sectors <= SECT_RESET;
    end else begin
      phase   <= phase_next;
      rest    <= rest_next;
      n_res   <= n_res_next;
      cur_op  <= cur_op_next;
      cursor  <= cursor_next;
      remain  <= remain_next;
      chunk   <= chunk_next;
      idb0    <= idb0_next;
      idb1    <= idb1_next;
      idx     <= idx_next;
      sectors <= sectors_next;
      if (load) pos <= '0;
      else if (out_fire) pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    list <= list_next;
  end

  a_no_load_emit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !q_pop) else $error("load during emit");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> pos < n_res) else $error("emit beyond list");
  a_rest_not_emit: assert property (@(posedge clk) disable iff (rst)
    rest != PH_EMIT) else $error("bad return phase");
endmodule
`default_nettype wire

// ===== rtl/spi_nor_flash_command_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_core: SPI NOR flash command sequencer
// Turns host requests, host write bytes and received SPI bytes into a stream
// of SPI actions (select, send, receive, wait, host data, done).
// ----------------------------------------------------------------------------
// A front queue of four items takes an item in any cycle it has room, so the
// host is held only while the queue is full. The back end takes one item per
// pass: it registers the item's result list as it takes it, then emits one
// result per cycle on the out channel while the channel is ready, and takes
// no new item until the list has drained. An erase gives 14 results.
// Unused kind items are dropped in the front and never reach the back end.
// Commands use 24-bit addresses; reads and writes split at 256-byte
// pages and the cursor wraps at 16 MiB. After a JEDEC ID read the sector
// count of the part is kept and reported on every done; it is 32 after reset.
// Host requests arriving while an operation is open and bytes of an unexpected
// kind produce no results.
`default_nettype none
module spi_nor_flash_command_sequencer_core (
  input  wire logic clk,
  input  wire logic rst,
  snfcs_in_if.sink   in_ch,
  snfcs_out_if.source out_ch
);
  import snfcs_pkg::*;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  snfcs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_pop  (q_pop)
  );

  snfcs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );
endmodule
`default_nettype wire
